// ===== hw/rtl/bnf_grammar_tokenizer_assert.svh =====
`ifndef BNF_GRAMMAR_TOKENIZER_ASSERT_SVH
`define BNF_GRAMMAR_TOKENIZER_ASSERT_SVH

// property checked on every rising clk edge, off while arst_n is low
`define BGT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form: when ante holds, cons holds in the same cycle
`define BGT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bgt_pkg.sv =====
package bgt_pkg;

	// token kinds
	localparam logic [3:0] KIND_IDENT    = 4'd0;
	localparam logic [3:0] KIND_NONTERM  = 4'd1;
	localparam logic [3:0] KIND_TERMINAL = 4'd2;
	localparam logic [3:0] KIND_ARROW    = 4'd3;
	localparam logic [3:0] KIND_OR       = 4'd4;
	localparam logic [3:0] KIND_LPAREN   = 4'd5;
	localparam logic [3:0] KIND_RPAREN   = 4'd6;
	localparam logic [3:0] KIND_ASSIGN   = 4'd7;
	localparam logic [3:0] KIND_END      = 4'd8;
	localparam logic [3:0] KIND_ERROR    = 4'd9;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNEXPECT  = 2'd1;
	localparam logic [1:0] ERR_OPEN_NT   = 2'd2;
	localparam logic [1:0] ERR_OPEN_TERM = 2'd3;

	// characters the scanner looks for
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// one token descriptor
	typedef struct packed {
		logic [3:0]  token_kind;
		logic [1:0]  error_code;
		logic [7:0]  bad_char;
		logic [15:0] token_line;
		logic [15:0] token_column;
		logic [23:0] token_offset;
		logic [15:0] token_length;
		logic        last_of_run;
	} result_t;

	// all descriptors caused by one byte, handed from scanner to output stage
	typedef struct packed {
		logic                valid;
		logic [2:0]          count;
		result_t [3:0]       slot;
	} bundle_t;

endpackage

// ===== hw/rtl/bgt_in_if.sv =====
interface bgt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       is_final;

	modport source (output valid, output char_byte, output is_final, input ready);
	modport sink (input valid, input char_byte, input is_final, output ready);
endinterface

// ===== hw/rtl/bgt_out_if.sv =====
interface bgt_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [1:0]  error_code;
	logic [7:0]  bad_char;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic [23:0] token_offset;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source (output valid, output token_kind, output error_code, output bad_char,
		output token_line, output token_column, output token_offset,
		output token_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input error_code, input bad_char,
		input token_line, input token_column, input token_offset,
		input token_length, input last_of_run, output ready);
endinterface

// ===== hw/rtl/bgt_scan.sv =====
module bgt_scan #(
	parameter int LINE_BITS   = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	bgt_in_if.sink           in_ch,
	input  logic             take,
	output bgt_pkg::bundle_t bundle
);

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_IDENT   = 3'd1;
	localparam logic [2:0] M_NONTERM = 3'd2;
	localparam logic [2:0] M_TERM    = 3'd3;
	localparam logic [2:0] M_COLON1  = 3'd4;
	localparam logic [2:0] M_COLON2  = 3'd5;

	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
	localparam logic [OFFSET_BITS-1:0] LEN_ONE  = OFFSET_BITS'(1);

	// input stage
	logic [7:0] char_s1;
	logic       fin_s1;
	logic       v_s1_q;

	// scanner state
	logic [2:0]             mode_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [LINE_BITS-1:0]   col_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [OFFSET_BITS-1:0] soff_q;
	logic [LINE_BITS-1:0]   scol_q;

	logic                   consume;
	logic [7:0]             c;
	logic                   is_alnum;
	logic                   is_space;
	logic [LINE_BITS-1:0]   line1;
	logic [LINE_BITS-1:0]   col1;
	logic [OFFSET_BITS-1:0] off1;
	logic [2:0]             mode_n;
	logic [OFFSET_BITS-1:0] soff_n;
	logic [LINE_BITS-1:0]   scol_n;
	logic                   rescan;
	logic                   ended;
	logic [2:0]             n;
	bgt_pkg::bundle_t       bnd;

	function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [23:0] sat_off(input logic [OFFSET_BITS-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'd16777215) ? 24'hFFFFFF : w[23:0];
	endfunction

	function automatic logic [15:0] sat_len(input logic [OFFSET_BITS-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] b,
		input logic [OFFSET_BITS-1:0] s);
		return (b >= s) ? b - s : '0;
	endfunction

	function automatic bgt_pkg::result_t mk(input logic [3:0] kind, input logic [1:0] code,
		input logic [7:0] bad, input logic [LINE_BITS-1:0] line,
		input logic [LINE_BITS-1:0] col, input logic [OFFSET_BITS-1:0] off,
		input logic [OFFSET_BITS-1:0] len);
		bgt_pkg::result_t r;
		r.token_kind   = kind;
		r.error_code   = code;
		r.bad_char     = bad;
		r.token_line   = sat_line(line);
		r.token_column = sat_line(col);
		r.token_offset = sat_off(off);
		r.token_length = sat_len(len);
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	// input register, freed when the output stage takes the bundle
	assign consume      = v_s1_q && take;
	assign in_ch.ready  = !v_s1_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			v_s1_q <= 1'b1;
		end else if (consume) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1 <= in_ch.char_byte;
			fin_s1  <= in_ch.is_final;
		end
	end

	// character classes
	assign c        = char_s1;
	assign is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
		|| (c >= 8'h61 && c <= 8'h7A);
	assign is_space = (c == bgt_pkg::CH_SPACE) || (c >= bgt_pkg::CH_TAB && c <= bgt_pkg::CH_CR);

	// position after this byte, each count saturating at its maximum
	always_comb begin
		off1 = (off_q != OFF_MAX) ? off_q + LEN_ONE : off_q;
		if (c == bgt_pkg::CH_LF) begin
			line1 = (line_q != LINE_MAX) ? line_q + LINE_ONE : line_q;
			col1  = LINE_ONE;
		end else begin
			line1 = line_q;
			col1  = (col_q != LINE_MAX) ? col_q + LINE_ONE : col_q;
		end
	end

	// token decisions for one byte: close open item, rescan, end of input
	always_comb begin
		bnd    = '0;
		n      = 3'd0;
		mode_n = mode_q;
		soff_n = soff_q;
		scol_n = scol_q;
		rescan = 1'b0;
		ended  = 1'b0;

		// close or continue the open item
		case (mode_q)
			M_NONTERM: begin
				if (c == bgt_pkg::CH_GT) begin
					bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_NONTERM, bgt_pkg::ERR_NONE, 8'h00,
						line1, scol_q, soff_q, span(off1, soff_q));
					n = n + 3'd1;
					mode_n = M_IDLE;
				end
			end
			M_TERM: begin
				if (c == bgt_pkg::CH_QUOTE) begin
					bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_TERMINAL, bgt_pkg::ERR_NONE, 8'h00,
						line1, scol_q, soff_q, span(off1, soff_q));
					n = n + 3'd1;
					mode_n = M_IDLE;
				end
			end
			M_IDENT: begin
				if (!(is_alnum || c == bgt_pkg::CH_UNDER)) begin
					bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_IDENT, bgt_pkg::ERR_NONE, 8'h00,
						line_q, scol_q, soff_q, span(off_q, soff_q));
					n = n + 3'd1;
					mode_n = M_IDLE;
					rescan = 1'b1;
				end
			end
			M_COLON1: begin
				if (c == bgt_pkg::CH_COLON) begin
					mode_n = M_COLON2;
				end else begin
					bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_ERROR, bgt_pkg::ERR_UNEXPECT,
						bgt_pkg::CH_COLON, line_q, scol_q, soff_q, span(off_q, soff_q));
					n = n + 3'd1;
					mode_n = M_IDLE;
					rescan = 1'b1;
				end
			end
			M_COLON2: begin
				if (c == bgt_pkg::CH_EQUAL) begin
					bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_ARROW, bgt_pkg::ERR_NONE, 8'h00,
						line1, scol_q, soff_q, span(off1, soff_q));
					mode_n = M_IDLE;
				end else begin
					bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_ERROR, bgt_pkg::ERR_UNEXPECT,
						bgt_pkg::CH_COLON, line_q, scol_q, soff_q, span(off_q, soff_q));
					mode_n = M_IDLE;
					rescan = 1'b1;
				end
				n = n + 3'd1;
			end
			default: begin
				mode_n = M_IDLE;
				rescan = 1'b1;
			end
		endcase

		// scan the byte from idle
		if (rescan) begin
			soff_n = off_q;
			scol_n = col_q;
			if (c == bgt_pkg::CH_NUL) begin
				ended = 1'b1;
			end else if (!is_space) begin
				case (c)
					bgt_pkg::CH_LT:    mode_n = M_NONTERM;
					bgt_pkg::CH_QUOTE: mode_n = M_TERM;
					bgt_pkg::CH_COLON: mode_n = M_COLON1;
					bgt_pkg::CH_BAR: begin
						bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_OR, bgt_pkg::ERR_NONE, 8'h00,
							line1, col_q, off_q, LEN_ONE);
						n = n + 3'd1;
					end
					bgt_pkg::CH_LPAREN: begin
						bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_LPAREN, bgt_pkg::ERR_NONE, 8'h00,
							line1, col_q, off_q, LEN_ONE);
						n = n + 3'd1;
					end
					bgt_pkg::CH_RPAREN: begin
						bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_RPAREN, bgt_pkg::ERR_NONE, 8'h00,
							line1, col_q, off_q, LEN_ONE);
						n = n + 3'd1;
					end
					bgt_pkg::CH_EQUAL: begin
						bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_ASSIGN, bgt_pkg::ERR_NONE, 8'h00,
							line1, col_q, off_q, LEN_ONE);
						n = n + 3'd1;
					end
					default: begin
						if (is_alnum) begin
							mode_n = M_IDENT;
						end else begin
							bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_ERROR, bgt_pkg::ERR_UNEXPECT,
								c, line1, col_q, off_q, LEN_ONE);
							n = n + 3'd1;
						end
					end
				endcase
			end
		end

		// last byte of the stream closes whatever is open
		if (fin_s1 && !ended) begin
			case (mode_n)
				M_IDENT: begin
					bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_IDENT, bgt_pkg::ERR_NONE, 8'h00,
						line1, scol_n, soff_n, span(off1, soff_n));
					n = n + 3'd1;
				end
				M_NONTERM: begin
					bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_ERROR, bgt_pkg::ERR_OPEN_NT, 8'h00,
						line1, scol_n, soff_n, span(off1, soff_n));
					n = n + 3'd1;
				end
				M_TERM: begin
					bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_ERROR, bgt_pkg::ERR_OPEN_TERM, 8'h00,
						line1, scol_n, soff_n, span(off1, soff_n));
					n = n + 3'd1;
				end
				M_COLON1, M_COLON2: begin
					bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_ERROR, bgt_pkg::ERR_UNEXPECT,
						bgt_pkg::CH_COLON, line1, scol_n, soff_n, span(off1, soff_n));
					n = n + 3'd1;
				end
				default: ;
			endcase
			ended = 1'b1;
		end

		// end token at the position after the byte
		if (ended) begin
			bnd.slot[n[1:0]] = mk(bgt_pkg::KIND_END, bgt_pkg::ERR_NONE, 8'h00,
				line1, col1, off1, '0);
			n = n + 3'd1;
		end

		bnd.valid = v_s1_q;
		bnd.count = n;
	end

	assign bundle = bnd;

	// state update when the bundle moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			line_q <= LINE_ONE;
			col_q  <= LINE_ONE;
			off_q  <= '0;
			soff_q <= '0;
			scol_q <= LINE_ONE;
		end else if (consume) begin
			if (ended) begin
				mode_q <= M_IDLE;
				line_q <= LINE_ONE;
				col_q  <= LINE_ONE;
				off_q  <= '0;
				soff_q <= '0;
				scol_q <= LINE_ONE;
			end else begin
				mode_q <= mode_n;
				line_q <= line1;
				col_q  <= col1;
				off_q  <= off1;
				soff_q <= soff_n;
				scol_q <= scol_n;
			end
		end
	end

endmodule

// ===== hw/rtl/bgt_emit.sv =====
module bgt_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  bgt_pkg::bundle_t bundle,
	output logic             take,
	bgt_out_if.source        out_ch
);

	logic [2:0]              cnt_q;
	logic [1:0]              idx_q;
	bgt_pkg::result_t [3:0]  slot_q;

	bgt_pkg::result_t        cur;
	logic                    last_w;
	logic                    pop;
	logic                    load;

	// current descriptor and end of its run
	assign cur    = slot_q[idx_q];
	assign last_w = ({1'b0, idx_q} == (cnt_q - 3'd1));
	assign pop    = out_ch.valid && out_ch.ready;

	// room for a new bundle when empty or draining its last descriptor
	assign take = (cnt_q == 3'd0) || (pop && last_w);
	assign load = take && bundle.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= bundle.count;
			idx_q <= 2'd0;
		end else if (pop) begin
			if (last_w) begin
				cnt_q <= 3'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= bundle.slot;
		end
	end

	// output channel
	assign out_ch.valid        = (cnt_q != 3'd0);
	assign out_ch.token_kind   = cur.token_kind;
	assign out_ch.error_code   = cur.error_code;
	assign out_ch.bad_char     = cur.bad_char;
	assign out_ch.token_line   = cur.token_line;
	assign out_ch.token_column = cur.token_column;
	assign out_ch.token_offset = cur.token_offset;
	assign out_ch.token_length = cur.token_length;
	assign out_ch.last_of_run  = last_w;

endmodule

// ===== hw/rtl/bnf_grammar_tokenizer.sv =====
// channel   dir  payload                                          transaction
// in_ch     in   char_byte, is_final                              valid & ready
// out_ch    out  token_kind, error_code, bad_char, token_line,    valid & ready
//                token_column, token_offset, token_length, last_of_run
//
// a byte waits in the input register until the result register takes it; its
// descriptors then leave one per cycle while out_ch is ready
// one byte per cycle while out_ch is ready and each byte yields at most one
// descriptor; a byte with more (up to three) keeps the result register until
// all are taken; reset puts line and column at 1, offset at 0, no clearing pass
// a stalled out_ch fills the input register, then in_ch.ready drops
module bnf_grammar_tokenizer #(
	parameter int LINE_BITS   = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	bgt_in_if.sink    in_ch,
	bgt_out_if.source out_ch
);

	bgt_pkg::bundle_t bundle;
	logic             take;

	bgt_scan #(
		.LINE_BITS   (LINE_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.take   (take),
		.bundle (bundle)
	);

	bgt_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.bundle (bundle),
		.take   (take),
		.out_ch (out_ch)
	);

endmodule

// ===== hw/rtl/bgt_checker.sv =====
`include "bnf_grammar_tokenizer_assert.svh"

module bgt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  token_kind,
	input logic [1:0]  error_code,
	input logic [23:0] token_offset,
	input logic [15:0] token_length,
	input logic        last_of_run
);

	// a stalled descriptor stays offered
	`BGT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "out valid dropped")

	// a stalled descriptor keeps its contents
	`BGT_ASSERT(a_out_stable, (out_valid && !out_ready) |=> ($stable(token_kind) && $stable(error_code) && $stable(token_offset) && $stable(token_length) && $stable(last_of_run)), "out payload changed")

	// the end token always closes the run of its byte
	`BGT_ASSERT_IMP(a_end_last, out_valid && token_kind == bgt_pkg::KIND_END, last_of_run, "end not last")

	// a byte taken during a stall fills the input register
	`BGT_ASSERT(a_backpressure, (in_valid && in_ready && out_valid && !out_ready) ##1 (!out_ready) |-> !in_ready, "input not stalled")

endmodule

bind bnf_grammar_tokenizer bgt_checker u_bgt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.token_kind   (out_ch.token_kind),
	.error_code   (out_ch.error_code),
	.token_offset (out_ch.token_offset),
	.token_length (out_ch.token_length),
	.last_of_run  (out_ch.last_of_run)
);
